### rtl/plasma_text_graphics_pixel_gen_core_assert.svh
// Assertion macros for the plasma pixel generator.
// Used by the top level only; needs no package.
`ifndef PLASMA_TEXT_GRAPHICS_PIXEL_GEN_CORE_ASSERT_SVH
`define PLASMA_TEXT_GRAPHICS_PIXEL_GEN_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define PTG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("pixel generator check failed");

// Next-cycle implication.
`define PTG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("pixel generator check failed");

`endif

### rtl/ptg_pkg.sv
// Shared types, constants and functions of the plasma pixel generator.
// No dependencies; imported by every module of the block but ptg_font_ram.
`default_nettype none

package ptg_pkg;

	localparam int GLYPH_COUNT  = 2048;
	localparam int GLYPH_ROWS   = 16;
	localparam int TEXT_COLUMNS = 80;

	localparam int GLYPH_AW  = $clog2(GLYPH_COUNT);
	localparam int ROW_AW    = $clog2(GLYPH_ROWS);
	localparam int STORE_AW  = GLYPH_AW + ROW_AW;
	localparam int CELL_AW   = 15;
	localparam int PADDR_W   = 5;
	localparam int PDATA_W   = 32;

	// Glyph offsets: bold/thin half and font set stride.
	localparam logic [10:0] BOLD_OFFSET     = 11'd256;
	localparam int          FONT_SET_SHIFT  = 9;

	// Bits of mode_bits.
	localparam int MODE_WIDE  = 0;
	localparam int MODE_GFX   = 1;
	localparam int MODE_VIDEO = 3;
	localparam int MODE_HIRES = 4;
	localparam int MODE_BLINK = 5;

	// Cursor start bits 6:5 with this value turn the cursor off.
	localparam logic [1:0] CURSOR_OFF_CODE = 2'b01;

	localparam logic REQ_FONT_WRITE = 1'b0;
	localparam logic REQ_RENDER     = 1'b1;

	localparam logic [4:0] COUNT_NONE   = 5'd0;
	localparam logic [4:0] COUNT_NARROW = 5'd8;
	localparam logic [4:0] COUNT_DOUBLE = 5'd16;

	typedef enum logic [2:0] {
		REG_ATTR_MAP,
		REG_MODE_BITS,
		REG_FONT_OPTS,
		REG_CURSOR_START,
		REG_CURSOR_END,
		REG_CURSOR_ADDRESS,
		REG_START_ADDRESS,
		REG_GRAPHICS_FG_ON
	} ptg_reg_e;

	localparam logic [3:0]  RST_ATTR_MAP       = 4'd4;
	localparam logic [5:0]  RST_MODE_BITS      = 6'd9;
	localparam logic [2:0]  RST_FONT_OPTS      = 3'd7;
	localparam logic [6:0]  RST_CURSOR_START   = 7'd6;
	localparam logic [3:0]  RST_CURSOR_END     = 4'd7;
	localparam logic [14:0] RST_CURSOR_ADDRESS = 15'd0;
	localparam logic [14:0] RST_START_ADDRESS  = 15'd0;
	localparam logic        RST_GRAPHICS_FG_ON = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [14:0] font_address;
		logic [7:0]  font_byte;
		logic [8:0]  display_line;
		logic [6:0]  column;
		logic [7:0]  char_byte;
		logic [7:0]  attr_byte;
		logic        blink_phase;
	} ptg_req_t;

	typedef struct packed {
		logic [15:0] pixels;
		logic [4:0]  pixel_count;
		logic [10:0] glyph_used;
		logic        cursor_shown;
	} ptg_res_t;

	typedef struct packed {
		logic [3:0]  attr_map;
		logic [5:0]  mode_bits;
		logic [2:0]  font_opts;
		logic [6:0]  cursor_start;
		logic [3:0]  cursor_end;
		logic [14:0] cursor_address;
		logic [14:0] start_address;
		logic        graphics_fg_on;
	} ptg_cfg_t;

	// What the decode stage hands to the shading stage for one item.
	typedef struct packed {
		logic        is_write;
		logic        is_gfx;
		logic        wide;
		logic        fg;
		logic        bg;
		logic        drawcur;
		logic [10:0] glyph;
		logic [15:0] gfx_pix;
	} ptg_cell_t;

	typedef struct packed {
		logic bg;
		logic fg;
		logic bold;
	} ptg_colors_t;

	// Attribute map: background and foreground levels plus bold select.
	function automatic ptg_colors_t attr_lookup(input logic [7:0] n, input logic [3:0] amap,
		input logic blinkmap);
		logic nb, nf, bb, bf, b, inv;
		logic [3:0] lo;
		ptg_colors_t r;
		nb = 1'b1; nf = 1'b0; bb = 1'b1; bf = 1'b0;
		b  = n[3];
		lo = n[3:0];
		if (n >= 8'h11 && n[2:0] != 3'd0) begin
			inv = amap[2];
			nb = inv; bb = inv; nf = ~inv; bf = ~inv;
			if (amap[3]) b = 1'b1;
		end
		if (n[6:4] == 3'd0) begin
			if (lo >= 4'h1 && lo <= 4'he && lo != 4'h7) begin
				inv = amap[0];
				bb = inv; bf = ~inv;
				if (!n[7]) begin
					nb = inv; nf = ~inv;
					if (amap[1]) b = 1'b1;
				end
			end
			if (lo == 4'h7 || lo == 4'hf) begin
				bb = 1'b0; bf = 1'b1;
				if (!n[7]) begin
					nb = 1'b0; nf = 1'b1;
				end
			end
		end
		if (n >= 8'h81 && n <= 8'h8f) begin
			nb = 1'b0; nf = 1'b1;
			b  = n[3];
		end
		// Equal nibbles give an all-black cell in the normal map.
		if (n[7:4] == n[3:0]) begin
			nb = 1'b0; nf = 1'b0;
		end
		// Same for the blink map, ignoring bit 7, up to 77h.
		if (!n[3] && n[6:4] == n[2:0]) begin
			bb = 1'b0; bf = 1'b0;
		end
		r.bg   = blinkmap ? bb : nb;
		r.fg   = blinkmap ? bf : nf;
		r.bold = b;
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/plasma_text_graphics_pixel_gen_core.sv
// Top level of the plasma panel pixel generator: channels, pipeline and
// output register. Depends on ptg_pkg, ptg_regs, ptg_cell_decode, ptg_font_ram.
//
//   Channel   Handshake             Payload            Direction
//   cmd       cmd_valid/cmd_ready   ptg_req_t cmd      in
//   pix       pix_valid/pix_ready   ptg_res_t pix      out
//   config    APB psel/penable      paddr/pwdata       in, prdata out
//
// One item is taken per cycle when the output side keeps up. The single
// port of the font store sees one access per item: a font write stores its
// byte at the edge that accepts the item, a render item starts its font read
// at that same edge. The item then waits in stage 1; its result enters the
// output register, and pix_valid rises, when stage 1 moves on. Reset clears
// the pipeline valid bits and sets the registers to their reset values; the
// font store is not cleared. A stalled output holds the item in the output
// register while the stage behind it, and then the input, fill up.
`default_nettype none

module plasma_text_graphics_pixel_gen_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cmd_valid,
	output logic                               cmd_ready,
	input  wire ptg_pkg::ptg_req_t             cmd,
	output logic                               pix_valid,
	input  wire logic                          pix_ready,
	output ptg_pkg::ptg_res_t                  pix,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [ptg_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [ptg_pkg::PDATA_W-1:0]   pwdata,
	output logic      [ptg_pkg::PDATA_W-1:0]   prdata,
	output logic                               pready
);
	import ptg_pkg::*;

	ptg_cfg_t            cfg;
	ptg_cell_t           cell_s0, cell_s1;
	logic                valid_s1;
	logic                mem_we;
	logic [STORE_AW-1:0] mem_addr;
	logic [7:0]          row_s1;
	logic                accept, adv_s1;
	logic                out_valid_q;
	ptg_res_t            out_q, res_s1;
	logic [15:0]         text_pix;
	logic                v;

	ptg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ptg_cell_decode u_decode (
		.req       (cmd),
		.cfg       (cfg),
		.mem_we    (mem_we),
		.mem_addr  (mem_addr),
		.cell_info (cell_s0)
	);

	// The font store is accessed only at acceptance, so its read register
	// holds the row of the item in stage 1 for as long as that item waits.
	// A write followed at once by a read of the same entry needs no
	// forwarding: the write lands at the earlier edge.
	ptg_font_ram #(
		.AW (STORE_AW),
		.DW (8)
	) u_font (
		.clk   (clk),
		.en    (accept),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (cmd.font_byte),
		.rdata (row_s1)
	);

	// Stage 1 moves on whenever the output register is empty or being read.
	assign adv_s1    = valid_s1 && (!out_valid_q || pix_ready);
	assign cmd_ready = !valid_s1 || adv_s1;
	assign accept    = cmd_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cell_s1 <= cell_s0;
		end
	end

	// Text shading: each glyph bit picks foreground or background, the
	// cursor inverts, and in 40-column mode each pixel is doubled.
	always_comb begin
		text_pix = '0;
		for (int c = 0; c < 8; c++) begin
			v = (row_s1[7 - c] ? cell_s1.fg : cell_s1.bg) ^ cell_s1.drawcur;
			if (cell_s1.wide) begin
				text_pix[15 - c] = v;
			end else begin
				text_pix[15 - 2*c] = v;
				text_pix[14 - 2*c] = v;
			end
		end
	end

	// Font writes give an all-zero result; graphics results carry no glyph
	// and never show the cursor.
	always_comb begin
		res_s1 = '0;
		if (!cell_s1.is_write) begin
			if (cell_s1.is_gfx) begin
				res_s1.pixels      = cell_s1.gfx_pix;
				res_s1.pixel_count = COUNT_NARROW;
			end else begin
				res_s1.pixels       = text_pix;
				res_s1.pixel_count  = cell_s1.wide ? COUNT_NARROW : COUNT_DOUBLE;
				res_s1.glyph_used   = cell_s1.glyph;
				res_s1.cursor_shown = cell_s1.drawcur;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (pix_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_q <= res_s1;
		end
	end

	assign pix_valid = out_valid_q;
	assign pix       = out_q;

	`include "plasma_text_graphics_pixel_gen_core_assert.svh"

	// An accepted item always occupies stage 1 on the next cycle.
	`PTG_ASSERT_NXT(a_accept_fills_s1, clk, arst_n, accept, valid_s1)
	// A result has one of the three legal pixel counts.
	`PTG_ASSERT_IMP(a_count_legal, clk, arst_n, out_valid_q, (out_q.pixel_count == COUNT_NONE || out_q.pixel_count == COUNT_NARROW || out_q.pixel_count == COUNT_DOUBLE))
	// A font write result is all zero.
	`PTG_ASSERT_IMP(a_write_zero, clk, arst_n, out_valid_q && out_q.pixel_count == COUNT_NONE, out_q.pixels == 16'h0000 && out_q.glyph_used == 11'd0 && !out_q.cursor_shown)
	// Eight-pixel results leave the low byte black.
	`PTG_ASSERT_IMP(a_narrow_low_zero, clk, arst_n, out_valid_q && out_q.pixel_count == COUNT_NARROW, out_q.pixels[7:0] == 8'h00)

endmodule

`default_nettype wire

### rtl/ptg_font_ram.sv
// Single-port synchronous RAM with registered read data.
// Generic; no package needed.
`default_nettype none

module ptg_font_ram #(
	parameter int AW = 15,
	parameter int DW = 8
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic          we,
	input  wire logic [AW-1:0] addr,
	input  wire logic [DW-1:0] wdata,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en && we) begin
			mem[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (en && !we) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### rtl/ptg_regs.sv
// APB configuration registers of the plasma pixel generator.
// Depends on ptg_pkg.
`default_nettype none

module ptg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [ptg_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [ptg_pkg::PDATA_W-1:0]   pwdata,
	output logic      [ptg_pkg::PDATA_W-1:0]   prdata,
	output logic                               pready,
	output ptg_pkg::ptg_cfg_t                  cfg
);
	import ptg_pkg::*;

	ptg_cfg_t cfg_q;
	ptg_reg_e sel;
	logic     wr_en;

	assign sel    = ptg_reg_e'(paddr[PADDR_W-1:2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.attr_map       <= RST_ATTR_MAP;
			cfg_q.mode_bits      <= RST_MODE_BITS;
			cfg_q.font_opts      <= RST_FONT_OPTS;
			cfg_q.cursor_start   <= RST_CURSOR_START;
			cfg_q.cursor_end     <= RST_CURSOR_END;
			cfg_q.cursor_address <= RST_CURSOR_ADDRESS;
			cfg_q.start_address  <= RST_START_ADDRESS;
			cfg_q.graphics_fg_on <= RST_GRAPHICS_FG_ON;
		end else if (wr_en) begin
			unique case (sel)
				REG_ATTR_MAP:       cfg_q.attr_map       <= pwdata[3:0];
				REG_MODE_BITS:      cfg_q.mode_bits      <= pwdata[5:0];
				REG_FONT_OPTS:      cfg_q.font_opts      <= pwdata[2:0];
				REG_CURSOR_START:   cfg_q.cursor_start   <= pwdata[6:0];
				REG_CURSOR_END:     cfg_q.cursor_end     <= pwdata[3:0];
				REG_CURSOR_ADDRESS: cfg_q.cursor_address <= pwdata[14:0];
				REG_START_ADDRESS:  cfg_q.start_address  <= pwdata[14:0];
				REG_GRAPHICS_FG_ON: cfg_q.graphics_fg_on <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (sel)
			REG_ATTR_MAP:       prdata = PDATA_W'(cfg_q.attr_map);
			REG_MODE_BITS:      prdata = PDATA_W'(cfg_q.mode_bits);
			REG_FONT_OPTS:      prdata = PDATA_W'(cfg_q.font_opts);
			REG_CURSOR_START:   prdata = PDATA_W'(cfg_q.cursor_start);
			REG_CURSOR_END:     prdata = PDATA_W'(cfg_q.cursor_end);
			REG_CURSOR_ADDRESS: prdata = PDATA_W'(cfg_q.cursor_address);
			REG_START_ADDRESS:  prdata = PDATA_W'(cfg_q.start_address);
			REG_GRAPHICS_FG_ON: prdata = PDATA_W'(cfg_q.graphics_fg_on);
			default:            prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### rtl/ptg_cell_decode.sv
// Decode stage: font store address, attribute colors, cursor match, glyph
// choice and graphics pixels for one item. Depends on ptg_pkg.
`default_nettype none

module ptg_cell_decode (
	input  wire ptg_pkg::ptg_req_t           req,
	input  wire ptg_pkg::ptg_cfg_t           cfg,
	output logic                             mem_we,
	output logic [ptg_pkg::STORE_AW-1:0]     mem_addr,
	output ptg_pkg::ptg_cell_t               cell_info
);
	import ptg_pkg::*;

	logic               enabled, wide, blinkmode, add_half;
	logic [ROW_AW-1:0]  sc;
	logic [CELL_AW-1:0] cols, line_base, cell_addr;
	logic               curline, drawcur, blink;
	ptg_colors_t        colors;
	logic [10:0]        glyph_sum, glyph;
	logic [15:0]        hires_pix, dither_pix;
	logic [1:0]         p;

	assign enabled   = cfg.mode_bits[MODE_VIDEO];
	assign wide      = cfg.mode_bits[MODE_WIDE];
	assign blinkmode = cfg.mode_bits[MODE_BLINK];
	assign sc        = req.display_line[ROW_AW-1:0];

	// Cell address: start + character row times line width + column.
	assign cols      = wide ? CELL_AW'(TEXT_COLUMNS) : CELL_AW'(TEXT_COLUMNS / 2);
	assign line_base = CELL_AW'(req.display_line[8:ROW_AW]) * cols;
	assign cell_addr = cfg.start_address + line_base + CELL_AW'(req.column);

	assign curline = (cfg.cursor_start[6:5] != CURSOR_OFF_CODE)
		&& ({cfg.cursor_start[3:0], 1'b0} <= {1'b0, sc})
		&& ({cfg.cursor_end, 1'b0} >= {1'b0, sc});
	assign drawcur = (cell_addr == cfg.cursor_address) && curline && enabled
		&& req.blink_phase;
	assign blink   = req.blink_phase && blinkmode && req.attr_byte[7] && !drawcur;

	assign colors  = attr_lookup(req.attr_byte, cfg.attr_map, blinkmode);

	// The thin swap bit flips which half of the font set holds bold glyphs.
	assign add_half  = ~(cfg.font_opts[2] ^ colors.bold);
	assign glyph_sum = {3'b000, req.char_byte} + (add_half ? BOLD_OFFSET : 11'd0)
		+ (11'(cfg.font_opts[1:0]) << FONT_SET_SHIFT);
	assign glyph     = 11'(glyph_sum[GLYPH_AW-1:0]);

	assign hires_pix = {req.char_byte & {8{enabled && cfg.graphics_fg_on}}, 8'h00};

	// Two-bit ordered dither: level 1 lights even lines, level 2 alternates
	// the lit half by line parity, level 3 is solid.
	always_comb begin
		dither_pix = '0;
		for (int c = 0; c < 4; c++) begin
			p = enabled ? req.char_byte[7 - 2*c -: 2] : 2'b00;
			case (p)
				2'd1: dither_pix[15 - 2*c] = ~req.display_line[0];
				2'd2: begin
					dither_pix[15 - 2*c] = ~req.display_line[0];
					dither_pix[14 - 2*c] = req.display_line[0];
				end
				2'd3: begin
					dither_pix[15 - 2*c] = 1'b1;
					dither_pix[14 - 2*c] = 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		mem_we             = (req.req_type == REQ_FONT_WRITE);
		mem_addr           = mem_we ? req.font_address[STORE_AW-1:0]
			: {glyph[GLYPH_AW-1:0], sc};
		cell_info.is_write = mem_we;
		cell_info.is_gfx   = cfg.mode_bits[MODE_GFX];
		cell_info.wide     = wide;
		cell_info.bg       = colors.bg;
		cell_info.fg       = blink ? colors.bg : colors.fg;
		cell_info.drawcur  = drawcur;
		cell_info.glyph    = glyph;
		cell_info.gfx_pix  = cfg.mode_bits[MODE_HIRES] ? hires_pix : dither_pix;
	end

endmodule

`default_nettype wire

### dv/plasma_text_graphics_pixel_gen_core_tb.sv
// Self-checking testbench for the plasma panel pixel generator core.
// Depends on ptg_pkg and the RTL of plasma_text_graphics_pixel_gen_core;
// it has its own predictor of the pixel stream and drives all three ports.
`timescale 1ns / 1ps

module plasma_text_graphics_pixel_gen_core_tb;
	import ptg_pkg::*;

	// How long the receiver refuses results in the back-pressure phase.
	localparam int HOLD_CYCLES = 160;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic cmd_valid = 1'b0;
	logic cmd_ready;
	ptg_req_t cmd = '0;

	logic pix_valid;
	logic pix_ready;
	ptg_res_t pix;

	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	// The receiver is ready when its random stall is over and no long hold is on.
	logic rx_ready = 1'b0;
	logic hold_off = 1'b0;
	assign pix_ready = rx_ready & ~hold_off;

	plasma_text_graphics_pixel_gen_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.pix_valid(pix_valid),
		.pix_ready(pix_ready),
		.pix(pix),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Shadow of the register file, updated by each register write. The
	// predictor and the item generator both read it; it only changes while
	// the block has nothing in flight.
	ptg_cfg_t panel_cfg = '{
		RST_ATTR_MAP, RST_MODE_BITS, RST_FONT_OPTS, RST_CURSOR_START,
		RST_CURSOR_END, RST_CURSOR_ADDRESS, RST_START_ADDRESS, RST_GRAPHICS_FG_ON
	};

	// Font contents as the block should hold them once each accepted item has
	// been applied, and a record, kept at generation time, of which glyph rows
	// have been given a write. Text items are only generated for rows that are
	// known, so the block never reads an unwritten font entry.
	logic [7:0] font_copy [0:32767];
	bit font_written [0:32767];

	ptg_req_t pending_cmds [$];
	ptg_res_t expected_pixels [$];
	int items_queued = 0;
	int items_accepted = 0;
	int mismatches = 0;

	// Percentage of decision points at which each side starts an idle burst.
	int idle_pct = 0;
	bit cmd_fired = 1'b0;
	int send_gap = 0;
	int rx_stall = 0;
	bit hold_request = 1'b0;

	// Attributes that sit on the edges of the attribute map: equal nibbles,
	// the underline-style low range, the 81h-8Fh range and plain white.
	logic [7:0] attr_picks [16] = '{
		8'h00, 8'h07, 8'h08, 8'h0f, 8'h11, 8'h77, 8'h80, 8'h81,
		8'h87, 8'h88, 8'h8f, 8'hf0, 8'hff, 8'h70, 8'h0e, 8'h01
	};

	task automatic report_mismatch(string msg);
		mismatches++;
		if (mismatches <= 50)
			$display("%0t: mismatch: %s", $realtime, msg);
	endtask

	// Background level, foreground level and bold select of an attribute
	// byte under the current attribute map, in the normal or the blink map.
	function automatic ptg_colors_t attr_levels(logic [7:0] n, logic blinkmap);
		ptg_colors_t lv;
		logic nb, nf, bb, bf, inv;
		logic [7:0] lo;
		nb = 1'b1;
		nf = 1'b0;
		bb = 1'b1;
		bf = 1'b0;
		lo = n & 8'h7f;
		lv.bold = n[3];
		// High range: the inverse and bold bits of the upper attribute group.
		if (n >= 8'h11 && n[2:0] != 3'd0) begin
			inv = panel_cfg.attr_map[2];
			nb = inv;
			bb = inv;
			nf = ~inv;
			bf = ~inv;
			if (panel_cfg.attr_map[3])
				lv.bold = 1'b1;
		end
		// Low range 01h-0Eh, and its blinking copy at 81h-8Eh.
		if (n[7:4] == 4'h0 || n[7:4] == 4'h8) begin
			if (lo >= 8'h01 && lo <= 8'h0e && lo != 8'h07) begin
				inv = panel_cfg.attr_map[0];
				bb = inv;
				bf = ~inv;
				if (!n[7]) begin
					nb = inv;
					nf = ~inv;
					if (panel_cfg.attr_map[1])
						lv.bold = 1'b1;
				end
			end
			if (lo == 8'h07 || lo == 8'h0f) begin
				bb = 1'b0;
				bf = 1'b1;
				if (!n[7]) begin
					nb = 1'b0;
					nf = 1'b1;
				end
			end
		end
		if (n >= 8'h81 && n <= 8'h8f) begin
			nb = 1'b0;
			nf = 1'b1;
			lv.bold = n[3];
		end
		// Equal nibbles blank the cell; the blink map ignores bit 7 up to 77h.
		if (n % 8'h11 == 8'h00) begin
			nb = 1'b0;
			nf = 1'b0;
		end
		if (lo <= 8'h77 && lo % 8'h11 == 8'h00) begin
			bb = 1'b0;
			bf = 1'b0;
		end
		lv.bg = blinkmap ? bb : nb;
		lv.fg = blinkmap ? bf : nf;
		return lv;
	endfunction

	// Glyph picked for a character: the bold half or the thin half of the
	// 512-glyph set, swapped by the thin-font bit, then the font set offset.
	function automatic logic [10:0] glyph_for(logic [7:0] ch, logic [7:0] attr);
		ptg_colors_t lv;
		logic [10:0] g;
		lv = attr_levels(attr, panel_cfg.mode_bits[MODE_BLINK]);
		if (panel_cfg.font_opts[2])
			g = lv.bold ? {3'b000, ch} + BOLD_OFFSET : {3'b000, ch};
		else
			g = lv.bold ? {3'b000, ch} : {3'b000, ch} + BOLD_OFFSET;
		return g + (11'(panel_cfg.font_opts[1:0]) << FONT_SET_SHIFT);
	endfunction

	// The result one accepted item must produce, given the current registers
	// and font contents.
	function automatic ptg_res_t render_cell(ptg_req_t r);
		ptg_res_t o;
		ptg_colors_t lv;
		logic en, wide, on_row, drawcur, dim, v, i0, i1;
		logic [1:0] pair;
		logic [14:0] cell_addr;
		logic [7:0] glyph_row;
		int cols, sc;
		o = '0;
		if (r.req_type == REQ_FONT_WRITE)
			return o;
		en = panel_cfg.mode_bits[MODE_VIDEO];
		if (panel_cfg.mode_bits[MODE_GFX]) begin
			if (panel_cfg.mode_bits[MODE_HIRES]) begin
				for (int c = 0; c < 8; c++)
					o.pixels[15-c] = en & r.char_byte[7-c] & panel_cfg.graphics_fg_on;
			end else begin
				// Two bits per pixel pair, shaded by an ordered dither on odd
				// and even lines.
				for (int c = 0; c < 4; c++) begin
					pair = en ? r.char_byte[7-2*c -: 2] : 2'b00;
					i0 = 1'b0;
					i1 = 1'b0;
					case (pair)
						2'b01: i0 = ~r.display_line[0];
						2'b10: begin
							if (r.display_line[0])
								i1 = 1'b1;
							else
								i0 = 1'b1;
						end
						2'b11: begin
							i0 = 1'b1;
							i1 = 1'b1;
						end
						default: ;
					endcase
					o.pixels[15-2*c] = i0;
					o.pixels[14-2*c] = i1;
				end
			end
			o.pixel_count = COUNT_NARROW;
			return o;
		end
		wide = panel_cfg.mode_bits[MODE_WIDE];
		cols = wide ? TEXT_COLUMNS : TEXT_COLUMNS / 2;
		sc = int'(r.display_line[3:0]);
		cell_addr = 15'(int'(panel_cfg.start_address) + int'(r.display_line[8:4]) * cols +
			int'(r.column));
		if (panel_cfg.cursor_start[6:5] == CURSOR_OFF_CODE)
			on_row = 1'b0;
		else
			on_row = int'(panel_cfg.cursor_start[3:0]) * 2 <= sc &&
				int'(panel_cfg.cursor_end) * 2 >= sc;
		drawcur = cell_addr == panel_cfg.cursor_address && on_row && en && r.blink_phase;
		dim = r.blink_phase && panel_cfg.mode_bits[MODE_BLINK] && r.attr_byte[7] && !drawcur;
		lv = attr_levels(r.attr_byte, panel_cfg.mode_bits[MODE_BLINK]);
		if (dim)
			lv.fg = lv.bg;
		o.glyph_used = glyph_for(r.char_byte, r.attr_byte);
		glyph_row = font_copy[{o.glyph_used, r.display_line[3:0]}];
		for (int c = 0; c < 8; c++) begin
			v = (glyph_row[7-c] ? lv.fg : lv.bg) ^ drawcur;
			if (wide) begin
				o.pixels[15-c] = v;
			end else begin
				o.pixels[15-2*c] = v;
				o.pixels[14-2*c] = v;
			end
		end
		o.pixel_count = wide ? COUNT_NARROW : COUNT_DOUBLE;
		o.cursor_shown = drawcur;
		return o;
	endfunction

	// Sender. Inputs change on the falling edge. A pending item stays on the
	// bus until the rising edge that takes it; after that the next item is
	// offered at once, or an idle burst starts.
	always @(negedge clk) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else if (!cmd_valid || cmd_fired) begin
			if (send_gap > 0) begin
				send_gap--;
				cmd_valid <= 1'b0;
			end else if (pending_cmds.size() == 0) begin
				cmd_valid <= 1'b0;
			end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
				send_gap = $urandom_range(0, 8);
				cmd_valid <= 1'b0;
			end else begin
				cmd <= pending_cmds.pop_front();
				cmd_valid <= 1'b1;
			end
		end
	end

	// Receiver: random stall bursts.
	always @(negedge clk) begin
		if (!arst_n) begin
			rx_ready <= 1'b0;
		end else if (rx_stall > 0) begin
			rx_stall--;
			rx_ready <= 1'b0;
		end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			rx_stall = $urandom_range(0, 8);
			rx_ready <= 1'b0;
		end else begin
			rx_ready <= 1'b1;
		end
	end

	// Long hold of the output side. While it lasts the sender keeps offering,
	// so the output register and the stage behind it fill and the block has
	// to drop cmd_ready.
	initial forever begin
		@(negedge clk);
		if (hold_request) begin
			hold_request = 1'b0;
			hold_off <= 1'b1;
			repeat (HOLD_CYCLES) @(negedge clk);
			hold_off <= 1'b0;
		end
	end

	// Monitor. On each rising edge the result taken there is checked against
	// the oldest expectation first; then an item taken at the same edge gets
	// its expectation, and a font write updates the font copy.
	always @(posedge clk) begin : check_and_predict
		ptg_res_t want;
		if (!arst_n) begin
			cmd_fired = 1'b0;
		end else begin
			if (pix_valid && pix_ready) begin
				if (expected_pixels.size() == 0) begin
					report_mismatch($sformatf("result %h arrived with none expected", pix));
				end else begin
					want = expected_pixels.pop_front();
					if (pix.pixels !== want.pixels)
						report_mismatch($sformatf("pixels %h, expected %h",
							pix.pixels, want.pixels));
					if (pix.pixel_count !== want.pixel_count)
						report_mismatch($sformatf("pixel_count %0d, expected %0d",
							pix.pixel_count, want.pixel_count));
					if (pix.glyph_used !== want.glyph_used)
						report_mismatch($sformatf("glyph_used %h, expected %h",
							pix.glyph_used, want.glyph_used));
					if (pix.cursor_shown !== want.cursor_shown)
						report_mismatch($sformatf("cursor_shown %b, expected %b",
							pix.cursor_shown, want.cursor_shown));
				end
			end
			cmd_fired = cmd_valid && cmd_ready;
			if (cmd_fired) begin
				expected_pixels.push_back(render_cell(cmd));
				if (cmd.req_type == REQ_FONT_WRITE)
					font_copy[cmd.font_address] = cmd.font_byte;
				items_accepted++;
			end
		end
	end

	// One register write: setup cycle, then access cycle until pready.
	task automatic write_reg(ptg_reg_e idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_ATTR_MAP: panel_cfg.attr_map = val[3:0];
			REG_MODE_BITS: panel_cfg.mode_bits = val[5:0];
			REG_FONT_OPTS: panel_cfg.font_opts = val[2:0];
			REG_CURSOR_START: panel_cfg.cursor_start = val[6:0];
			REG_CURSOR_END: panel_cfg.cursor_end = val[3:0];
			REG_CURSOR_ADDRESS: panel_cfg.cursor_address = val[14:0];
			REG_START_ADDRESS: panel_cfg.start_address = val[14:0];
			REG_GRAPHICS_FG_ON: panel_cfg.graphics_fg_on = val[0];
			default: ;
		endcase
	endtask

	task automatic queue_cmd(ptg_req_t r);
		pending_cmds.push_back(r);
		items_queued++;
		if (r.req_type == REQ_FONT_WRITE)
			font_written[r.font_address] = 1'b1;
	endtask

	function automatic ptg_req_t random_fields();
		ptg_req_t r;
		r.req_type = 1'($urandom);
		r.font_address = 15'($urandom);
		r.font_byte = 8'($urandom);
		r.display_line = 9'($urandom_range(0, 399));
		r.column = 7'($urandom_range(0, 79));
		r.char_byte = 8'($urandom);
		r.attr_byte = 8'($urandom);
		r.blink_phase = 1'($urandom);
		return r;
	endfunction

	// Queue a render item. In text mode the glyph row it will read is given
	// a random write first if nothing has been written there yet.
	task automatic queue_render(ptg_req_t r);
		ptg_req_t w;
		logic [14:0] a;
		r.req_type = REQ_RENDER;
		if (!panel_cfg.mode_bits[MODE_GFX]) begin
			a = {glyph_for(r.char_byte, r.attr_byte), r.display_line[3:0]};
			if (!font_written[a]) begin
				w = random_fields();
				w.req_type = REQ_FONT_WRITE;
				w.font_address = a;
				queue_cmd(w);
			end
		end
		queue_cmd(r);
	endtask

	task automatic queue_text(int line, int col, logic [7:0] ch, logic [7:0] attr, bit ph);
		ptg_req_t r;
		r = random_fields();
		r.display_line = 9'(line);
		r.column = 7'(col);
		r.char_byte = ch;
		r.attr_byte = attr;
		r.blink_phase = ph;
		queue_render(r);
	endtask

	task automatic queue_font(logic [14:0] a, logic [7:0] b);
		ptg_req_t r;
		r = random_fields();
		r.req_type = REQ_FONT_WRITE;
		r.font_address = a;
		r.font_byte = b;
		queue_cmd(r);
	endtask

	// One random item: mostly renders, some stray font writes. When the cursor
	// cell is on screen, a quarter of the text renders are aimed at it so that
	// the cursor rows, the blink phase and the cursor-off code all get exercised.
	task automatic queue_random_item();
		ptg_req_t r;
		int cols, k;
		r = random_fields();
		if ($urandom_range(0, 9) == 0) begin
			r.req_type = REQ_FONT_WRITE;
			queue_cmd(r);
		end else begin
			if ($urandom_range(0, 1) == 1)
				r.attr_byte = attr_picks[$urandom_range(0, 15)];
			cols = panel_cfg.mode_bits[MODE_WIDE] ? TEXT_COLUMNS : TEXT_COLUMNS / 2;
			k = int'(15'(panel_cfg.cursor_address - panel_cfg.start_address));
			if (!panel_cfg.mode_bits[MODE_GFX] && $urandom_range(0, 3) == 0 && k < 25 * cols)
					begin
				r.display_line = 9'((k / cols) * 16 + $urandom_range(0, 15));
				r.column = 7'(k % cols);
			end
			queue_render(r);
		end
	endtask

	// Wait until every queued item has been taken and every result checked,
	// then let the pipeline settle.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (items_accepted != items_queued || expected_pixels.size() != 0);
		repeat (6) @(negedge clk);
	endtask

	task automatic run_phase(ptg_cfg_t c, int n, int idle, bit squeeze);
		write_reg(REG_ATTR_MAP, 32'(c.attr_map));
		write_reg(REG_MODE_BITS, 32'(c.mode_bits));
		write_reg(REG_FONT_OPTS, 32'(c.font_opts));
		write_reg(REG_CURSOR_START, 32'(c.cursor_start));
		write_reg(REG_CURSOR_END, 32'(c.cursor_end));
		write_reg(REG_CURSOR_ADDRESS, 32'(c.cursor_address));
		write_reg(REG_START_ADDRESS, 32'(c.start_address));
		write_reg(REG_GRAPHICS_FG_ON, 32'(c.graphics_fg_on));
		idle_pct = idle;
		if (squeeze)
			hold_request = 1'b1;
		repeat (n) queue_random_item();
		wait_drained();
	endtask

	function automatic ptg_cfg_t random_cfg(bit text_only);
		ptg_cfg_t c;
		c.attr_map = 4'($urandom);
		c.mode_bits = 6'($urandom);
		c.font_opts = 3'($urandom);
		c.cursor_start = 7'($urandom);
		c.cursor_end = 4'($urandom);
		c.start_address = 15'($urandom);
		c.cursor_address = 15'(c.start_address + $urandom_range(0, 999));
		c.graphics_fg_on = 1'($urandom);
		if (text_only)
			c.mode_bits[MODE_GFX] = 1'b0;
		return c;
	endfunction

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed items under the reset register values: 80 columns, text,
		// video on, cursor on rows 12 to 14 of cell 0. The write to the last
		// font entry is read back by the bold FFh character on line 399.
		idle_pct = 10;
		queue_font(15'h7fff, 8'hff);
		queue_font(15'h0000, 8'h00);
		queue_text(0, 0, 8'h00, 8'h00, 1'b0);
		queue_text(399, 79, 8'hff, 8'hff, 1'b1);
		queue_text(12, 0, 8'h41, 8'h07, 1'b1);
		queue_text(14, 0, 8'h41, 8'h07, 1'b0);
		queue_text(13, 0, 8'h5a, 8'h8f, 1'b1);
		queue_text(21, 7, 8'h80, 8'h0f, 1'b1);
		queue_text(37, 40, 8'h01, 8'h0e, 1'b0);
		queue_text(100, 3, 8'h7f, 8'h81, 1'b1);
		queue_text(257, 64, 8'hc3, 8'h88, 1'b1);
		queue_text(300, 12, 8'h3c, 8'h77, 1'b0);
		queue_text(255, 79, 8'hfe, 8'h70, 1'b1);
		wait_drained();

		// Text, 80 columns, all-zero options and the cursor over every row.
		run_phase('{4'h0, 6'h09, 3'h0, 7'h00, 4'hf, 15'd85, 15'd0, 1'b1}, 45, 15, 1'b0);
		// Text, 40 columns with blink; the cursor address wraps past 7FFFh.
		run_phase('{4'hf, 6'h28, 3'h7, 7'h7f, 4'hf, 15'd39, 15'h7fff, 1'b0}, 45, 15, 1'b0);
		// Graphics: direct pixels, then video off, then black foreground.
		run_phase('{4'h5, 6'h3f, 3'h2, 7'h06, 4'h7, 15'd0, 15'd0, 1'b1}, 45, 20, 1'b0);
		run_phase('{4'ha, 6'h12, 3'h1, 7'h06, 4'h7, 15'd0, 15'd0, 1'b1}, 45, 20, 1'b0);
		run_phase('{4'h3, 6'h1a, 3'h4, 7'h06, 4'h7, 15'd0, 15'd0, 1'b0}, 45, 20, 1'b0);
		// Graphics: dithered, with video on and off.
		run_phase('{4'h6, 6'h0a, 3'h0, 7'h00, 4'h0, 15'd0, 15'd0, 1'b1}, 45, 15, 1'b0);
		run_phase('{4'hc, 6'h02, 3'h5, 7'h00, 4'h0, 15'd0, 15'd0, 1'b1}, 45, 15, 1'b0);
		// Text with the cursor-off code and no idling on either side.
		run_phase('{4'h6, 6'h3d, 3'h5, 7'h2c, 4'hf, 15'd200, 15'd100, 1'b1}, 45, 0, 1'b0);
		// Text, 40 columns, video off: the cursor must never show.
		run_phase('{4'h9, 6'h00, 3'h3, 7'h00, 4'hf, 15'h7fff, 15'h7fff, 1'b1}, 45, 15, 1'b0);

		// Back pressure: the receiver holds off while items keep coming.
		run_phase(random_cfg(1'b1), 45, 5, 1'b1);
		repeat (3) run_phase(random_cfg(1'b0), 45, 25, 1'b0);
		run_phase(random_cfg(1'b0), 45, 10, 1'b0);
		// Last stretch with both sides always willing.
		run_phase(random_cfg(1'b1), 45, 0, 1'b0);

		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("[plasma_text_graphics_pixel_gen_core] OK");
		else
			$display("[plasma_text_graphics_pixel_gen_core] ERROR");
		$finish;
	end

	// Watchdog. A correct run ends well before the 3 ms limit even with every
	// idle burst at its longest.
	initial begin
		#3_000_000;
		$display("[plasma_text_graphics_pixel_gen_core] ERROR");
		$finish;
	end

endmodule
